// ----- rtl/slt_pkg.sv -----
// ----------------------------------------------------------------------------
// slt_pkg - shared types and constants of the source lexer
// Token kind codes, the result word layout and the push group that travels
// from the scanner to the output queue.
// ----------------------------------------------------------------------------
package slt_pkg;

  // Default length cap of a token
  localparam int unsigned MAX_TOKEN_LENGTH_DEF = 65535;

  // Output queue geometry
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Operator kinds: the two-character form of operator i is 2*i, the
  // single form 2*i+1, in the order = ! < > - &
  localparam logic [5:0] KIND_LBRACE   = 6'd12;
  localparam logic [5:0] KIND_RBRACE   = 6'd13;
  localparam logic [5:0] KIND_LPAREN   = 6'd14;
  localparam logic [5:0] KIND_RPAREN   = 6'd15;
  localparam logic [5:0] KIND_LBRACKET = 6'd16;
  localparam logic [5:0] KIND_RBRACKET = 6'd17;
  localparam logic [5:0] KIND_COMMA    = 6'd18;
  localparam logic [5:0] KIND_SEMI     = 6'd19;
  localparam logic [5:0] KIND_PLUS     = 6'd20;
  localparam logic [5:0] KIND_STAR     = 6'd21;
  localparam logic [5:0] KIND_SLASH    = 6'd22;
  localparam logic [5:0] KIND_COLON    = 6'd23;
  localparam logic [5:0] KIND_DOT      = 6'd24;
  localparam logic [5:0] KIND_INT      = 6'd25;
  localparam logic [5:0] KIND_CHR      = 6'd26;
  localparam logic [5:0] KIND_STR      = 6'd27;
  localparam logic [5:0] KIND_IDENT    = 6'd28;
  localparam logic [5:0] KIND_KW0      = 6'd29;
  localparam logic [5:0] KIND_ERR      = 6'd38;

  // One token word
  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] start;
    logic [15:0] length;
    logic [7:0]  error_byte;
    logic        last;
  } res_t;

  // Up to two words from one source byte; v1 is only set with v0
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

// ----- rtl/slt_byte_if.sv -----
// ----------------------------------------------------------------------------
// slt_byte_if - source byte channel
// Valid/ready channel carrying one source byte or an end-of-input marker.
// ----------------------------------------------------------------------------
interface slt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ----- rtl/slt_token_if.sv -----
// ----------------------------------------------------------------------------
// slt_token_if - token channel
// Valid/ready channel carrying one token word.
// ----------------------------------------------------------------------------
interface slt_token_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [31:0] token_start;
  logic [15:0] token_length;
  logic [7:0]  error_byte;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output error_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input error_byte, input last_of_run,
                  output ready);
endinterface

// ----- rtl/source_lexer_tokenizer.sv -----
// Datapath: input register, combinational scan, output queue feeding the token port.
// Throughput: one byte per cycle while the output queue has room for two words and
// each byte closes at most one token; a byte that closes a token and opens a second
// yields two words, and the single token port drains one word per cycle while ready.
// Reset: synchronous active-high rst returns the scanner to idle, clears the
// byte offset and empties the input register and the output queue.
// ----------------------------------------------------------------------------
// source_lexer_tokenizer - streaming source lexer
// Takes source bytes and emits tokens with kind, start offset and length.
// ----------------------------------------------------------------------------
module source_lexer_tokenizer #(
  parameter int unsigned MAX_TOKEN_LENGTH = slt_pkg::MAX_TOKEN_LENGTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  slt_byte_if.sink     byte_stream,
  slt_token_if.source  token_stream
);
  import slt_pkg::*;

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_eoi;
  logic       room;
  logic       advance;
  logic       not_empty;
  res_t       head;
  push_t      push;

  assign advance           = stage_valid && room;
  assign byte_stream.ready = !stage_valid || room;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (byte_stream.ready) begin
      stage_valid <= byte_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_stream.ready && byte_stream.valid) begin
      stage_byte <= byte_stream.in_byte;
      stage_eoi  <= byte_stream.end_of_input;
    end
  end

  slt_scan #(
    .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .go           (advance),
    .in_byte      (stage_byte),
    .end_of_input (stage_eoi),
    .push         (push)
  );

  slt_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (not_empty && token_stream.ready),
    .head      (head),
    .not_empty (not_empty),
    .room      (room)
  );

  // Token port
  assign token_stream.valid        = not_empty;
  assign token_stream.token_kind   = head.kind;
  assign token_stream.token_start  = head.start;
  assign token_stream.token_length = head.length;
  assign token_stream.error_byte   = head.error_byte;
  assign token_stream.last_of_run  = head.last;

endmodule

// ----- rtl/slt_scan.sv -----
// ----------------------------------------------------------------------------
// slt_scan - lexer scan state and token decision
// Holds the scanner state and, for each source byte, decides combinationally
// which tokens close (at most two) and what state follows.
// ----------------------------------------------------------------------------
module slt_scan #(
  parameter int unsigned MAX_TOKEN_LENGTH = slt_pkg::MAX_TOKEN_LENGTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  logic [7:0]      in_byte,
  input  logic            end_of_input,
  output slt_pkg::push_t  push
);
  import slt_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_OP, M_IDENT, M_NUM, M_CHR, M_STR
  } mode_t;

  typedef struct packed {
    logic       found;
    logic [2:0] idx;
  } op_t;

  typedef struct packed {
    logic       found;
    logic [5:0] kind;
  } punct_t;

  localparam logic [15:0] MaxLen = 16'(MAX_TOKEN_LENGTH);

  // Keyword table, right-aligned in the 48-bit window
  localparam logic [47:0] KW_TEXT [9] = '{
    48'("func"), 48'("struct"), 48'("var"), 48'("return"), 48'("if"),
    48'("else"), 48'("while"), 48'("i64"), 48'("char")
  };
  localparam logic [2:0] KW_LEN [9] = '{
    3'd4, 3'd6, 3'd3, 3'd6, 3'd2, 3'd4, 3'd5, 3'd3, 3'd4
  };

  function automatic op_t op_lookup(input logic [7:0] c);
    op_t o;
    o.found = 1'b1;
    case (c)
      "=":     o.idx = 3'd0;
      "!":     o.idx = 3'd1;
      "<":     o.idx = 3'd2;
      ">":     o.idx = 3'd3;
      "-":     o.idx = 3'd4;
      "&":     o.idx = 3'd5;
      default: begin
        o.found = 1'b0;
        o.idx   = 3'd0;
      end
    endcase
    return o;
  endfunction

  function automatic logic [7:0] op_second(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd4:    c = ">";
      3'd5:    c = "&";
      default: c = "=";
    endcase
    return c;
  endfunction

  function automatic punct_t punct_lookup(input logic [7:0] c);
    punct_t p;
    p.found = 1'b1;
    case (c)
      "{":     p.kind = KIND_LBRACE;
      "}":     p.kind = KIND_RBRACE;
      "(":     p.kind = KIND_LPAREN;
      ")":     p.kind = KIND_RPAREN;
      "[":     p.kind = KIND_LBRACKET;
      "]":     p.kind = KIND_RBRACKET;
      ",":     p.kind = KIND_COMMA;
      ";":     p.kind = KIND_SEMI;
      "+":     p.kind = KIND_PLUS;
      "*":     p.kind = KIND_STAR;
      "/":     p.kind = KIND_SLASH;
      ":":     p.kind = KIND_COLON;
      ".":     p.kind = KIND_DOT;
      default: begin
        p.found = 1'b0;
        p.kind  = KIND_ERR;
      end
    endcase
    return p;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  // State
  mode_t       mode, mode_next;
  logic [7:0]  pend_char, pend_char_next;
  logic [47:0] kw_window, kw_window_next;
  logic        esc, esc_next;
  logic [31:0] start_off, start_off_next;
  logic [15:0] run_len, run_len_next;
  logic [31:0] byte_pos, byte_pos_next;

  // Decision signals
  logic        do_flush, do_begin;
  logic        fl_v, bg_v;
  res_t        fl, bg;
  logic [15:0] len_grown, fl_len;
  logic [5:0]  ident_kind;
  logic [7:0]  quote;
  op_t         op_pend, op_new;
  punct_t      pn_new;

  // Keyword match, all nine compared side by side
  always_comb begin
    ident_kind = KIND_IDENT;
    for (int k = 0; k < 9; k++) begin
      if (fl_len == 16'(KW_LEN[k]) && kw_window == KW_TEXT[k]) begin
        ident_kind = 6'(KIND_KW0 + 6'(k));
      end
    end
  end

  always_comb begin
    mode_next      = mode;
    pend_char_next = pend_char;
    kw_window_next = kw_window;
    esc_next       = esc;
    start_off_next = start_off;
    run_len_next   = run_len;
    byte_pos_next  = byte_pos;
    do_flush       = 1'b0;
    do_begin       = 1'b0;
    fl_v           = 1'b0;
    bg_v           = 1'b0;
    fl             = '0;
    bg             = '0;
    op_pend        = op_lookup(pend_char);
    op_new         = op_lookup(in_byte);
    pn_new         = punct_lookup(in_byte);
    len_grown      = (run_len < MaxLen) ? run_len + 16'd1 : run_len;
    fl_len         = run_len;
    quote          = (mode == M_CHR) ? 8'h27 : 8'h22;

    // Per-mode handling of the incoming byte
    if (go) begin
      if (end_of_input) begin
        do_flush = 1'b1;
      end else begin
        byte_pos_next = byte_pos + 32'd1;
        if (in_byte == 8'h00) begin
          do_flush = 1'b1;
        end else begin
          unique case (mode)
            M_OP: begin
              if (op_pend.found && in_byte == op_second(op_pend.idx)) begin
                fl_v      = 1'b1;
                fl.kind   = 6'({op_pend.idx, 1'b0});
                fl.start  = start_off;
                fl.length = 16'd2;
                mode_next = M_IDLE;
              end else begin
                do_flush = 1'b1;
                do_begin = 1'b1;
              end
            end
            M_IDENT: begin
              if (in_byte == "_" || is_alpha(in_byte) || is_digit(in_byte)) begin
                run_len_next   = len_grown;
                kw_window_next = {kw_window[39:0], in_byte};
              end else begin
                do_flush = 1'b1;
                do_begin = 1'b1;
              end
            end
            M_NUM: begin
              if (is_digit(in_byte)) begin
                run_len_next = len_grown;
              end else begin
                do_flush = 1'b1;
                do_begin = 1'b1;
              end
            end
            M_CHR, M_STR: begin
              run_len_next = len_grown;
              if (esc) begin
                esc_next = 1'b0;
              end else if (in_byte == "\\") begin
                esc_next = 1'b1;
              end else if (in_byte == quote) begin
                do_flush = 1'b1;
                fl_len   = len_grown;
              end
            end
            M_IDLE: begin
              do_begin = 1'b1;
            end
            default: begin
              do_begin = 1'b1;
            end
          endcase
        end
      end
    end

    // Close the pending token as it stands
    if (do_flush) begin
      mode_next = M_IDLE;
      esc_next  = 1'b0;
      fl.start  = start_off;
      fl.length = fl_len;
      unique case (mode)
        M_OP: begin
          fl_v      = op_pend.found;
          fl.kind   = 6'({op_pend.idx, 1'b1});
          fl.length = 16'd1;
        end
        M_IDENT: begin
          fl_v    = 1'b1;
          fl.kind = ident_kind;
        end
        M_NUM: begin
          fl_v    = 1'b1;
          fl.kind = KIND_INT;
        end
        M_CHR: begin
          fl_v    = 1'b1;
          fl.kind = KIND_CHR;
        end
        M_STR: begin
          fl_v    = 1'b1;
          fl.kind = KIND_STR;
        end
        M_IDLE: begin
          fl_v = 1'b0;
        end
        default: begin
          fl_v = 1'b0;
        end
      endcase
    end

    // Scan the byte as the first of a new token
    if (do_begin) begin
      mode_next = M_IDLE;
      bg.start  = byte_pos;
      bg.length = 16'd1;
      if (!is_space(in_byte)) begin
        start_off_next = byte_pos;
        run_len_next   = 16'd1;
        esc_next       = 1'b0;
        if (op_new.found) begin
          mode_next      = M_OP;
          pend_char_next = in_byte;
        end else if (pn_new.found) begin
          bg_v    = 1'b1;
          bg.kind = pn_new.kind;
        end else if (in_byte == 8'h27) begin
          mode_next = M_CHR;
        end else if (in_byte == 8'h22) begin
          mode_next = M_STR;
        end else if (in_byte == "_" || is_alpha(in_byte)) begin
          mode_next      = M_IDENT;
          kw_window_next = 48'(in_byte);
        end else if (is_digit(in_byte)) begin
          mode_next = M_NUM;
        end else begin
          bg_v          = 1'b1;
          bg.kind       = KIND_ERR;
          bg.error_byte = in_byte;
        end
      end
    end
  end

  // Pack the closed tokens in order, marking the final one
  always_comb begin
    push = '0;
    if (fl_v) begin
      push.v0      = 1'b1;
      push.r0      = fl;
      push.r0.last = !bg_v;
      push.v1      = bg_v;
      push.r1      = bg;
      push.r1.last = 1'b1;
    end else begin
      push.v0      = bg_v;
      push.r0      = bg;
      push.r0.last = 1'b1;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      pend_char <= '0;
      kw_window <= '0;
      esc       <= 1'b0;
      start_off <= '0;
      run_len   <= '0;
      byte_pos  <= '0;
    end else begin
      mode      <= mode_next;
      pend_char <= pend_char_next;
      kw_window <= kw_window_next;
      esc       <= esc_next;
      start_off <= start_off_next;
      run_len   <= run_len_next;
      byte_pos  <= byte_pos_next;
    end
  end

endmodule

// ----- rtl/slt_out_queue.sv -----
// ----------------------------------------------------------------------------
// slt_out_queue - token output queue
// Small queue taking up to two token words a cycle and handing out one.
// ----------------------------------------------------------------------------
module slt_out_queue (
  input  logic            clk,
  input  logic            rst,
  input  slt_pkg::push_t  push,
  input  logic            pop,
  output slt_pkg::res_t   head,
  output logic            not_empty,
  output logic            room
);
  import slt_pkg::*;

  res_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic [1:0]          n_push;

  assign n_push    = {1'b0, push.v0} + {1'b0, push.v1};
  assign not_empty = (count != '0);
  // Room for two words, judged on the registered fill level
  assign room      = (count <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
  assign head      = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.v1) begin
      mem[wr_ptr + QUEUE_AW'(1)] <= push.r1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_AW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      count <= count + (QUEUE_AW+1)'(n_push) - (QUEUE_AW+1)'(pop);
    end
  end

endmodule

// ----- dv/tb_source_lexer_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_source_lexer_tokenizer - self-checking bench for the source lexer
// Feeds source byte words into the block and predicts every token word from
// its own scanner model. Each token word leaving the block is checked field by
// field against the oldest prediction. Runs directed token sequences, a long
// receiver hold-off, a saturating token and random token streams with
// varying idle rates on both channels.
// ----------------------------------------------------------------------------
module tb_source_lexer_tokenizer;
  import slt_pkg::*;

  localparam int unsigned MAX_LEN     = MAX_TOKEN_LENGTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_OP, SCAN_IDENT, SCAN_NUM, SCAN_CHR, SCAN_STR
  } scan_e;

  logic clk = 1'b0;
  logic rst;

  slt_byte_if  byte_ch ();
  slt_token_if token_ch ();

  source_lexer_tokenizer dut (
    .clk          (clk),
    .rst          (rst),
    .byte_stream  (byte_ch),
    .token_stream (token_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scanner model state
  scan_e       scan;
  logic [7:0]  op_lead;
  logic [47:0] ident_tail;
  logic        esc_armed;
  logic [31:0] tok_start;
  logic [15:0] tok_len;
  logic [31:0] next_pos;

  res_t burst[$];
  res_t expected_tokens[$];

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic        rx_hold     = 1'b0;
  int unsigned words_sent  = 0;
  int unsigned tokens_seen = 0;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  // --------------------------------------------------------------------------
  // Character classes
  // --------------------------------------------------------------------------
  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word_char(logic [7:0] c);
    return c == "_" || is_letter(c) || is_digit(c);
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || c == "\t" || c == CH_CR || c == "\n";
  endfunction

  // Operator slot: the two-byte form is kind 2*slot, the single form 2*slot+1
  function automatic int op_slot(logic [7:0] c);
    case (c)
      "=":     return 0;
      "!":     return 1;
      "<":     return 2;
      ">":     return 3;
      "-":     return 4;
      "&":     return 5;
      default: return -1;
    endcase
  endfunction

  function automatic logic [7:0] op_follow(int slot);
    case (slot)
      4:       return ">";
      5:       return "&";
      default: return "=";
    endcase
  endfunction

  function automatic int punct_code(logic [7:0] c);
    case (c)
      "{":     return int'(KIND_LBRACE);
      "}":     return int'(KIND_RBRACE);
      "(":     return int'(KIND_LPAREN);
      ")":     return int'(KIND_RPAREN);
      "[":     return int'(KIND_LBRACKET);
      "]":     return int'(KIND_RBRACKET);
      ",":     return int'(KIND_COMMA);
      ";":     return int'(KIND_SEMI);
      "+":     return int'(KIND_PLUS);
      "*":     return int'(KIND_STAR);
      "/":     return int'(KIND_SLASH);
      ":":     return int'(KIND_COLON);
      ".":     return int'(KIND_DOT);
      default: return -1;
    endcase
  endfunction

  // Keyword lookup on the last six identifier bytes and the length
  function automatic logic [5:0] ident_word_kind();
    logic [47:0] kw_text [9];
    int unsigned kw_size [9];
    kw_text = '{48'("func"), 48'("struct"), 48'("var"), 48'("return"), 48'("if"),
                48'("else"), 48'("while"), 48'("i64"), 48'("char")};
    kw_size = '{4, 6, 3, 6, 2, 4, 5, 3, 4};
    for (int k = 0; k < 9; k++) begin
      if (int'(tok_len) == kw_size[k] && ident_tail == kw_text[k])
        return KIND_KW0 + 6'(k);
    end
    return KIND_IDENT;
  endfunction

  // --------------------------------------------------------------------------
  // Scanner model
  // --------------------------------------------------------------------------
  function automatic void reset_scanner();
    scan       = SCAN_IDLE;
    op_lead    = 8'd0;
    ident_tail = 48'd0;
    esc_armed  = 1'b0;
    tok_start  = 32'd0;
    tok_len    = 16'd0;
    next_pos   = 32'd0;
  endfunction

  function automatic void note_token(logic [5:0] kind, logic [31:0] start,
                                     logic [15:0] len, logic [7:0] eb);
    res_t r;
    r.kind       = kind;
    r.start      = start;
    r.length     = len;
    r.error_byte = eb;
    r.last       = 1'b0;
    burst.push_back(r);
  endfunction

  function automatic void lengthen();
    if (int'(tok_len) < MAX_LEN) tok_len = tok_len + 16'd1;
  endfunction

  // Emit the pending token as it stands; operators take their single form
  function automatic void close_token();
    int slot;
    slot = op_slot(op_lead);
    case (scan)
      SCAN_OP:    if (slot >= 0) note_token(6'(2 * slot + 1), tok_start, 16'd1, 8'd0);
      SCAN_IDENT: note_token(ident_word_kind(), tok_start, tok_len, 8'd0);
      SCAN_NUM:   note_token(KIND_INT, tok_start, tok_len, 8'd0);
      SCAN_CHR:   note_token(KIND_CHR, tok_start, tok_len, 8'd0);
      SCAN_STR:   note_token(KIND_STR, tok_start, tok_len, 8'd0);
      default:    ;
    endcase
    scan      = SCAN_IDLE;
    esc_armed = 1'b0;
  endfunction

  // Scan a byte as the first byte of a new token
  function automatic void open_token(logic [7:0] b, logic [31:0] pos);
    int pk;
    pk   = punct_code(b);
    scan = SCAN_IDLE;
    if (is_blank(b)) return;
    tok_start = pos;
    tok_len   = 16'd1;
    esc_armed = 1'b0;
    if (op_slot(b) >= 0) begin
      scan    = SCAN_OP;
      op_lead = b;
    end else if (pk >= 0) begin
      note_token(6'(pk), pos, 16'd1, 8'd0);
    end else if (b == CH_QUOTE) begin
      scan = SCAN_CHR;
    end else if (b == CH_DQUOTE) begin
      scan = SCAN_STR;
    end else if (b == "_" || is_letter(b)) begin
      scan       = SCAN_IDENT;
      ident_tail = {40'd0, b};
    end else if (is_digit(b)) begin
      scan = SCAN_NUM;
    end else begin
      note_token(KIND_ERR, pos, 16'd1, b);
    end
  endfunction

  // Work out the token words caused by one accepted byte word
  function automatic void predict_tokens(logic [7:0] b, logic eoi);
    logic [31:0] pos;
    int          slot;
    res_t        r;
    burst.delete();
    if (eoi) begin
      close_token();
    end else begin
      pos      = next_pos;
      next_pos = next_pos + 32'd1;
      slot     = op_slot(op_lead);
      if (b == CH_NUL) begin
        close_token();
      end else if (scan == SCAN_OP) begin
        if (slot >= 0 && op_follow(slot) == b) begin
          note_token(6'(2 * slot), tok_start, 16'd2, 8'd0);
          scan = SCAN_IDLE;
        end else begin
          close_token();
          open_token(b, pos);
        end
      end else if (scan == SCAN_IDENT) begin
        if (is_word_char(b)) begin
          lengthen();
          ident_tail = {ident_tail[39:0], b};
        end else begin
          close_token();
          open_token(b, pos);
        end
      end else if (scan == SCAN_NUM) begin
        if (is_digit(b)) begin
          lengthen();
        end else begin
          close_token();
          open_token(b, pos);
        end
      end else if (scan == SCAN_CHR || scan == SCAN_STR) begin
        // literal body: escapes swallow the next byte, the quote closes
        lengthen();
        if (esc_armed)
          esc_armed = 1'b0;
        else if (b == CH_BSLASH)
          esc_armed = 1'b1;
        else if (b == ((scan == SCAN_CHR) ? CH_QUOTE : CH_DQUOTE))
          close_token();
      end else begin
        open_token(b, pos);
      end
    end
    foreach (burst[i]) begin
      r      = burst[i];
      r.last = (i == burst.size() - 1);
      expected_tokens.push_back(r);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Byte word sender
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] b, input logic eoi);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid        <= 1'b1;
    byte_ch.in_byte      <= b;
    byte_ch.end_of_input <= eoi;
    do @(posedge clk); while (!byte_ch.ready);
    words_sent++;
    predict_tokens(b, eoi);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic send_flush();
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Stop offering and wait for every predicted word to come out
  task automatic drain_tokens();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
  endtask

  task automatic set_idle(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  // --------------------------------------------------------------------------
  // Random content helpers
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rand_word_byte(bit lead);
    int k;
    k = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
    if (k < 26) return 8'(8'h61 + k);
    if (k < 52) return 8'(8'h41 + k - 26);
    if (k == 52) return "_";
    return 8'(8'h30 + k - 53);
  endfunction

  task automatic send_literal(input logic [7:0] quote, input int max_body);
    int n;
    n = $urandom_range(0, max_body);
    send_word(quote, 1'b0);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) begin
        send_word(CH_BSLASH, 1'b0);
        send_word($urandom_range(0, 1) ? quote : 8'($urandom_range(1, 255)), 1'b0);
      end else begin
        send_word(8'($urandom_range(32, 126)), 1'b0);
      end
    end
    // mostly closed, sometimes left open for a NUL or flush to end
    if ($urandom_range(0, 9) != 0) send_word(quote, 1'b0);
  endtask

  task automatic send_random_token();
    string puncts;
    string blanks;
    string kw_pool [9];
    int    pick;
    int    slot;
    int    n;
    puncts  = "{}()[],;+*/:.";
    blanks  = " \t\n";
    kw_pool = '{"func", "struct", "var", "return", "if", "else", "while", "i64", "char"};
    pick    = $urandom_range(0, 99);
    if (pick < 12) begin
      slot = $urandom_range(0, 5);
      send_text(slot == 0 ? "=" : slot == 1 ? "!" : slot == 2 ? "<" :
                slot == 3 ? ">" : slot == 4 ? "-" : "&");
      if ($urandom_range(0, 1)) send_word(op_follow(slot), 1'b0);
    end else if (pick < 22) begin
      send_word(puncts[$urandom_range(0, puncts.len() - 1)], 1'b0);
    end else if (pick < 42) begin
      if ($urandom_range(0, 2) == 0) begin
        send_text(kw_pool[$urandom_range(0, 8)]);
      end else begin
        n = $urandom_range(0, 9);
        send_word(rand_word_byte(1'b1), 1'b0);
        repeat (n) send_word(rand_word_byte(1'b0), 1'b0);
      end
    end else if (pick < 52) begin
      n = $urandom_range(1, 8);
      repeat (n) send_word(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
    end else if (pick < 58) begin
      send_literal(CH_QUOTE, 2);
    end else if (pick < 66) begin
      send_literal(CH_DQUOTE, 8);
    end else if (pick < 80) begin
      if ($urandom_range(0, 3) == 0) send_word(CH_CR, 1'b0);
      else send_word(blanks[$urandom_range(0, 2)], 1'b0);
    end else if (pick < 84) begin
      send_word(CH_NUL, 1'b0);
    end else if (pick < 88) begin
      send_flush();
    end else begin
      send_word(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_operators();
    send_text("== != <= >= -> && = ! < > - & =;-x");
    send_text("<");
    send_word(CH_NUL, 1'b0);
    send_text("&");
    send_flush();
  endtask

  task automatic test_punct_and_errors();
    send_text("{}()[],;+*/:.@");
    send_word(8'h80, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'h01, 1'b0);
    send_text("a#");
  endtask

  task automatic test_keywords();
    send_text("func struct var return if(else while\ti64\nchar funcs iff x9 Var _");
    send_word(CH_CR, 1'b0);
    send_text("while");
    send_flush();
  endtask

  task automatic test_literals();
    send_text("'a' '\\'' \"a\\\"b\" '' 123 45x 'ab");
    send_word(CH_NUL, 1'b0);
    send_text("\"x\\");
    send_word(CH_NUL, 1'b0);
    send_text("\"open");
    send_flush();
    send_flush();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    set_idle(0, 0);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (40) send_text("a;");
    drain_tokens();
  endtask

  // Identifier long enough to saturate the length field
  task automatic test_long_token();
    set_idle(0, 0);
    send_word(rand_word_byte(1'b1), 1'b0);
    repeat (MAX_LEN + 4) send_word(rand_word_byte(1'b0), 1'b0);
    send_text(" ");
    drain_tokens();
  endtask

  task automatic test_random(input int unsigned count);
    int unsigned target;
    target = words_sent + count;
    while (words_sent < target) send_random_token();
    drain_tokens();
  endtask

  // --------------------------------------------------------------------------
  // Token sink and checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : token_sink
    res_t got;
    res_t want;
    if (rst) begin
      token_ch.ready <= 1'b0;
    end else begin
      if (token_ch.valid && token_ch.ready) begin
        got.kind       = token_ch.token_kind;
        got.start      = token_ch.token_start;
        got.length     = token_ch.token_length;
        got.error_byte = token_ch.error_byte;
        got.last       = token_ch.last_of_run;
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("token %0d: unexpected word kind %0d start %0d len %0d",
                     tokens_seen, got.kind, got.start, got.length);
        end else begin
          want = expected_tokens.pop_front();
          if (got.kind !== want.kind || got.start !== want.start ||
              got.length !== want.length || got.error_byte !== want.error_byte ||
              got.last !== want.last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"token %0d: exp kind %0d start %0d len %0d err %0h last %0b",
                        " / got kind %0d start %0d len %0d err %0h last %0b"},
                       tokens_seen, want.kind, want.start, want.length, want.error_byte,
                       want.last, got.kind, got.start, got.length, got.error_byte,
                       got.last);
          end
        end
      end
      token_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                  <= 1'b1;
    byte_ch.valid        <= 1'b0;
    byte_ch.in_byte      <= 8'd0;
    byte_ch.end_of_input <= 1'b0;
    reset_scanner();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // sender idles now and then, receiver mostly stalls
    set_idle(10, 74);
    test_operators();
    test_punct_and_errors();
    test_keywords();
    test_literals();
    drain_tokens();
    test_random(700);

    // sender mostly idle, receiver now and then
    set_idle(74, 10);
    test_random(700);

    // no idling on either side
    test_backpressure();
    test_long_token();
    set_idle(0, 0);
    test_random(600);

    drain_tokens();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_tokens.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
